[rtl/grs_pkg.sv]
`default_nettype none
package grs_pkg;

	localparam int MAX_GROUP_DEF = 64;
	localparam int VAL_W = 32;
	localparam int GS_W = 7;
	// count fields hold up to the largest group the block supports
	localparam int CNT_W = 7;

	typedef struct packed {
		logic bank;
		logic [CNT_W-1:0] count;
		logic rev;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic valid;
		logic bank;
	} done_t;

endpackage
`default_nettype wire

[rtl/grs_front.sv]
`default_nettype none
module grs_front #(
	parameter int MAX_GROUP = grs_pkg::MAX_GROUP_DEF,
	parameter int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic signed [grs_pkg::VAL_W-1:0] value,
	input wire logic final_req,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [grs_pkg::GS_W-1:0] group_size,
	input wire logic q_full,
	output logic q_push,
	output grs_pkg::cmd_t q_cmd,
	input wire grs_pkg::done_t done,
	output logic wr_en,
	output logic [AW:0] wr_addr,
	output logic [grs_pkg::VAL_W-1:0] wr_data
);

	logic [grs_pkg::GS_W-1:0] gs_q;
	logic [grs_pkg::CNT_W-1:0] fill_q;
	logic wbank_q;
	logic [1:0] busy_q;
	logic [1:0] busy_d;
	logic [grs_pkg::CNT_W-1:0] k;
	logic [grs_pkg::CNT_W-1:0] n;
	logic accept;
	logic full_grp;
	logic close;

	always_comb begin
		if (gs_q == '0) begin
			k = grs_pkg::CNT_W'(1);
		end else if (grs_pkg::CNT_W'(gs_q) > grs_pkg::CNT_W'(MAX_GROUP)) begin
			k = grs_pkg::CNT_W'(MAX_GROUP);
		end else begin
			k = grs_pkg::CNT_W'(gs_q);
		end
	end

	assign n = fill_q + grs_pkg::CNT_W'(1);
	// a new item may only land in a bank the back end has released, and only while the queue is not full
	assign in_stall = busy_q[wbank_q] | q_full;
	assign accept = in_valid & ~in_stall;
	assign full_grp = (n >= k);
	assign close = accept & (full_grp | final_req);

	assign cfg_ready = 1'b1;

	assign wr_en = accept;
	assign wr_addr = {wbank_q, fill_q[AW-1:0]};
	assign wr_data = value;

	assign q_push = close;
	assign q_cmd = '{bank: wbank_q, count: n, rev: full_grp, last: final_req};

	always_comb begin
		busy_d = busy_q;
		if (done.valid) begin
			busy_d[done.bank] = 1'b0;
		end
		if (close) begin
			busy_d[wbank_q] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gs_q <= grs_pkg::GS_W'(1);
			fill_q <= '0;
			wbank_q <= 1'b0;
			busy_q <= '0;
		end else begin
			busy_q <= busy_d;
			if (cfg_valid && cfg_ready) begin
				gs_q <= group_size;
			end
			if (accept) begin
				if (close) begin
					fill_q <= '0;
					wbank_q <= ~wbank_q;
				end else begin
					fill_q <= n;
				end
			end
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < grs_pkg::CNT_W'(MAX_GROUP))
		else $error("fill count reached group capacity");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done.valid |-> busy_q[done.bank])
		else $error("release of a bank that holds no group");

endmodule
`default_nettype wire

[rtl/grs_queue.sv]
`default_nettype none
module grs_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire grs_pkg::cmd_t push_cmd,
	output logic full,
	input wire logic pop,
	output logic valid,
	output grs_pkg::cmd_t head
);

	grs_pkg::cmd_t ent_q [2];
	logic rd_q;
	logic wr_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign head = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			unique case ({push, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("group queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid)
		else $error("group queue underflow");

endmodule
`default_nettype wire

[rtl/grs_back.sv]
`default_nettype none
module grs_back #(
	parameter int MAX_GROUP = grs_pkg::MAX_GROUP_DEF,
	parameter int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_en,
	input wire logic [AW:0] wr_addr,
	input wire logic [grs_pkg::VAL_W-1:0] wr_data,
	input wire logic q_valid,
	input wire grs_pkg::cmd_t q_cmd,
	output logic q_pop,
	output grs_pkg::done_t done,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [grs_pkg::VAL_W-1:0] value_res,
	output logic run_end,
	output logic sequence_end
);

	// two banks of one group each
	logic [grs_pkg::VAL_W-1:0] mem [2**(AW+1)];

	grs_pkg::cmd_t cmd_q;
	logic active_q;
	logic [grs_pkg::CNT_W-1:0] idx_q;
	logic out_valid_q;
	logic [grs_pkg::VAL_W-1:0] value_q;
	logic run_end_q;
	logic seq_end_q;
	logic out_load;
	logic is_end;
	logic finish;
	logic [grs_pkg::CNT_W-1:0] ridx;
	logic [AW:0] raddr;

	assign out_load = active_q & (~out_valid_q | ~out_stall);
	assign is_end = (idx_q + grs_pkg::CNT_W'(1) == cmd_q.count);
	assign finish = out_load & is_end;
	assign q_pop = q_valid & (~active_q | finish);
	assign done = '{valid: finish, bank: cmd_q.bank};

	// full groups read back from the top, short leftovers from the bottom
	assign ridx = cmd_q.rev ? (cmd_q.count - grs_pkg::CNT_W'(1) - idx_q) : idx_q;
	assign raddr = {cmd_q.bank, ridx[AW-1:0]};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (out_load) begin
			value_q <= mem[raddr];
			run_end_q <= is_end;
			seq_end_q <= is_end & cmd_q.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q <= '0;
			cmd_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				cmd_q <= q_cmd;
				idx_q <= '0;
				active_q <= 1'b1;
			end else if (finish) begin
				active_q <= 1'b0;
			end else if (out_load) begin
				idx_q <= idx_q + grs_pkg::CNT_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign value_res = value_q;
	assign run_end = run_end_q;
	assign sequence_end = seq_end_q;

	a_idx_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (idx_q < cmd_q.count))
		else $error("read index past end of group");

endmodule
`default_nettype wire

[rtl/group_reverse_stream_top.sv]
`default_nettype none
// path: group commands go via the queue to the back end; outputs are registered
// throughput: up to one item per cycle while the input is not stalled; the back end
// takes up a queued group as it sends the last item of the one before; input stalls
// while the queue is full or the bank it would fill holds a group not fully sent
// reset: async active low, clears fill count, queue, bank flags; group size returns to 1
module group_reverse_stream_top #(
	parameter int MAX_GROUP = grs_pkg::MAX_GROUP_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic signed [grs_pkg::VAL_W-1:0] value,
	input wire logic final_req,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [grs_pkg::VAL_W-1:0] value_res,
	output logic run_end,
	output logic sequence_end,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [grs_pkg::GS_W-1:0] group_size
);

	localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_valid;
	grs_pkg::cmd_t push_cmd;
	grs_pkg::cmd_t head_cmd;
	grs_pkg::done_t done;
	logic wr_en;
	logic [AW:0] wr_addr;
	logic [grs_pkg::VAL_W-1:0] wr_data;

	grs_front #(.MAX_GROUP(MAX_GROUP), .AW(AW)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.value(value),
		.final_req(final_req),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.group_size(group_size),
		.q_full(q_full),
		.q_push(q_push),
		.q_cmd(push_cmd),
		.done(done),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	grs_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_cmd(push_cmd),
		.full(q_full),
		.pop(q_pop),
		.valid(q_valid),
		.head(head_cmd)
	);

	grs_back #(.MAX_GROUP(MAX_GROUP), .AW(AW)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.q_valid(q_valid),
		.q_cmd(head_cmd),
		.q_pop(q_pop),
		.done(done),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.value_res(value_res),
		.run_end(run_end),
		.sequence_end(sequence_end)
	);

endmodule
`default_nettype wire
